// File: src/hcbd_pkg.sv
// Shared types, constants and helpers of the HTTP chunked body decoder.
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam int unsigned SIZE_LINE_LIMIT_DEF = 32;
    localparam int unsigned CHUNK_SIZE_BITS_DEF = 64;
    localparam logic [31:0] MAX_BODY_RESET      = 32'd1048576;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_SIZE_LF = 3'd1,
        PH_DATA    = 3'd2,
        PH_DATA_CR = 3'd3,
        PH_DATA_LF = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_NONE   = 3'd0,
        ST_DONE   = 3'd1,
        ST_TRUNC  = 3'd2,
        ST_LONG   = 3'd3,
        ST_OVF    = 3'd4,
        ST_BIG    = 3'd5,
        ST_BADEND = 3'd6
    } status_t;

    typedef struct packed {
        logic        has_result;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [31:0] body_length;
        logic [31:0] consumed_bytes;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // Decode one ASCII hex digit, either case.
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// File: src/hcbd_core.sv
// Per-byte chunk parser: message state registers and next-state/result logic.
`timescale 1ns / 1ps

module hcbd_core #(
    parameter int unsigned SIZE_LINE_LIMIT = hcbd_pkg::SIZE_LINE_LIMIT_DEF,
    parameter int unsigned CHUNK_SIZE_BITS = hcbd_pkg::CHUNK_SIZE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              end_of_input,
    input  logic [31:0]       max_body_length,
    output hcbd_pkg::result_t result
);
    import hcbd_pkg::*;

    localparam int unsigned LCW  = $clog2(SIZE_LINE_LIMIT);
    localparam int unsigned CSB  = CHUNK_SIZE_BITS;
    localparam int unsigned CMPW = (CSB > 32) ? CSB : 32;

    phase_t          phase_reg, phase_next;
    logic [LCW-1:0]  line_reg, line_next;
    logic [CSB-1:0]  acc_reg, acc_next;
    logic            ended_reg, ended_next;
    logic [CSB-1:0]  rem_reg, rem_next;
    logic [31:0]     body_reg, body_next;
    logic [31:0]     cons_reg, cons_next;
    logic            final_reg, final_next;

    logic [31:0]     cons_inc;
    logic [LCW:0]    line_p1;
    logic [31:0]     room;
    logic [CSB-1:0]  rem_dec;
    hex_t            hex;
    status_t         st;
    logic            pv;
    logic [31:0]     blen;
    logic [31:0]     cons_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIZE;
            line_reg  <= '0;
            acc_reg   <= '0;
            ended_reg <= 1'b0;
            rem_reg   <= '0;
            body_reg  <= '0;
            cons_reg  <= '0;
            final_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            line_reg  <= line_next;
            acc_reg   <= acc_next;
            ended_reg <= ended_next;
            rem_reg   <= rem_next;
            body_reg  <= body_next;
            cons_reg  <= cons_next;
            final_reg <= final_next;
        end
    end

    always_comb begin
        cons_inc   = (cons_reg == 32'hFFFF_FFFF) ? cons_reg : cons_reg + 32'd1;
        line_p1    = {1'b0, line_reg} + {{LCW{1'b0}}, 1'b1};
        room       = max_body_length - body_reg;
        rem_dec    = (rem_reg != '0) ? rem_reg - {{(CSB-1){1'b0}}, 1'b1} : rem_reg;
        hex        = hex_decode(data_byte);

        phase_next = phase_reg;
        line_next  = line_reg;
        acc_next   = acc_reg;
        ended_next = ended_reg;
        rem_next   = rem_reg;
        body_next  = body_reg;
        cons_next  = cons_inc;
        final_next = final_reg;
        st         = ST_NONE;
        pv         = 1'b0;
        blen       = '0;
        cons_out   = '0;

        unique case (phase_reg)
            PH_SIZE: begin
                if (data_byte == CH_CR) begin
                    if (body_reg > max_body_length ||
                        CMPW'(acc_reg) > CMPW'(room)) begin
                        st = ST_BIG;
                    end else begin
                        phase_next = PH_SIZE_LF;
                    end
                end else if (line_p1 >= (LCW+1)'(SIZE_LINE_LIMIT)) begin
                    st = ST_LONG;
                end else begin
                    line_next = line_p1[LCW-1:0];
                    if (!ended_reg) begin
                        if (!hex.ok) begin
                            ended_next = 1'b1;
                        end else if (acc_reg[CSB-1:CSB-4] != 4'd0) begin
                            st = ST_OVF;
                        end else begin
                            acc_next = {acc_reg[CSB-5:0], hex.value};
                        end
                    end
                end
            end
            PH_SIZE_LF: begin
                if (data_byte != CH_LF) begin
                    st = ST_BADEND;
                end else if (acc_reg == '0) begin
                    final_next = 1'b1;
                    phase_next = PH_DATA_CR;
                end else begin
                    rem_next   = acc_reg;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                pv        = 1'b1;
                body_next = body_reg + 32'd1;
                rem_next  = rem_dec;
                if (rem_dec == '0) begin
                    phase_next = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (data_byte != CH_CR) begin
                    st = ST_BADEND;
                end else begin
                    phase_next = PH_DATA_LF;
                end
            end
            PH_DATA_LF: begin
                if (data_byte != CH_LF) begin
                    st = ST_BADEND;
                end else if (final_reg) begin
                    st       = ST_DONE;
                    blen     = body_reg;
                    cons_out = cons_inc;
                end else begin
                    phase_next = PH_SIZE;
                    line_next  = '0;
                    acc_next   = '0;
                    ended_next = 1'b0;
                end
            end
            default: begin
                phase_next = PH_SIZE;
            end
        endcase

        if (st == ST_NONE && end_of_input) begin
            st = ST_TRUNC;
        end
        if (st != ST_NONE) begin
            phase_next = PH_SIZE;
            line_next  = '0;
            acc_next   = '0;
            ended_next = 1'b0;
            rem_next   = '0;
            body_next  = '0;
            cons_next  = '0;
            final_next = 1'b0;
        end

        result.has_result     = pv || (st != ST_NONE);
        result.payload_valid  = pv;
        result.payload_byte   = pv ? data_byte : 8'd0;
        result.status         = st;
        result.body_length    = blen;
        result.consumed_bytes = cons_out;
    end

endmodule

// File: src/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder: ports, input and result registers.
`timescale 1ns / 1ps

//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+----------------------------------------------
//  s_       | in        | s_valid / s_ready  | s_data_byte, s_end_of_input
//  m_       | out       | m_valid / m_ready  | m_payload_valid, m_payload_byte, m_status,
//           |           |                    | m_body_length, m_consumed_bytes
//  cfg_     | in        | cfg_wr_en          | cfg_wr_data (max_body_length)
//
//  One byte per clock, sustained while m_ready is high. A byte lands in the input
//  register, is parsed there by the state update in hcbd_core once the result register
//  is free or being emptied, and its transaction (if it produces one) is registered onto m_.
//  Reset is synchronous on aresetn low; it clears the message state and loads
//  max_body_length with 1048576. A stall on m_ready holds the result register
//  and the input register; s_ready drops only when both are occupied and
//  m_ready is low.

module http_chunked_body_decoder #(
    parameter int unsigned SIZE_LINE_LIMIT = hcbd_pkg::SIZE_LINE_LIMIT_DEF,
    parameter int unsigned CHUNK_SIZE_BITS = hcbd_pkg::CHUNK_SIZE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_input,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic [2:0]  m_status,
    output logic [31:0] m_body_length,
    output logic [31:0] m_consumed_bytes
);
    import hcbd_pkg::*;

    // Configuration register.
    logic [31:0] max_body_reg;

    // Input register: one byte waiting to be parsed.
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_data_reg;
    logic        in_eoi_reg;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg;

    result_t     core_res;
    logic        s_take;
    logic        advance;

    // Parse the held byte when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_body_reg <= MAX_BODY_RESET;
        end else if (cfg_wr_en) begin
            max_body_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        // Advance the input stage: a new byte fills it or replaces the one being parsed.
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        // Load a transaction only when the parsed byte produced one; drop it once taken.
        if (advance) begin
            out_valid_next = core_res.has_result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers hold their value while stalled.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_data_reg <= s_data_byte;
            in_eoi_reg  <= s_end_of_input;
        end
        if (advance) begin
            res_reg <= core_res;
        end
    end

    hcbd_core #(
        .SIZE_LINE_LIMIT (SIZE_LINE_LIMIT),
        .CHUNK_SIZE_BITS (CHUNK_SIZE_BITS)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .data_byte       (in_data_reg),
        .end_of_input    (in_eoi_reg),
        .max_body_length (max_body_reg),
        .result          (core_res)
    );

    assign m_valid          = out_valid_reg;
    assign m_payload_valid  = res_reg.payload_valid;
    assign m_payload_byte   = res_reg.payload_byte;
    assign m_status         = res_reg.status;
    assign m_body_length    = res_reg.body_length;
    assign m_consumed_bytes = res_reg.consumed_bytes;

    // A transaction always carries a body byte or a status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload_valid || m_status != ST_NONE))
        else $error("empty result transaction");

    // Completion never carries a body byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_DONE) |-> !m_payload_valid)
        else $error("done status carried a payload byte");

    // Length and count are reported with done only.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_DONE) |-> (m_body_length == 32'd0 &&
                                              m_consumed_bytes == 32'd0))
        else $error("length fields set without done");

    // A byte held in the input register is not lost while parsing is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("stalled input byte lost");

endmodule

// File: tb/http_chunked_body_decoder_tb.sv
// Self-checking testbench of the HTTP chunked body decoder: directed table, then random streams.
`timescale 1ns / 1ps

module http_chunked_body_decoder_tb;
    import hcbd_pkg::*;

    localparam int unsigned LINE_LIMIT = 32;
    localparam int unsigned SIZE_BITS  = 64;

    // Cycles to let pass once nothing is due: the block holds a byte in its input
    // register first, and a byte that yields no transaction leaves no trace to wait on.
    localparam int LATENCY_PAD     = 8;
    localparam int LONG_HOLD       = 400;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int PHASES          = 5;

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PATTERN, RX_SPARSE} rx_mode_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [31:0] body_length;
        logic [31:0] consumed_bytes;
    } decoded_t;

    // One stream byte; directed rows may carry a typed-in expectation.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
        logic       fixed;
        logic       fixed_has;
        decoded_t   fixed_res;
    } byte_item_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [31:0] cfg_wr_data    = 32'd0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte    = 8'd0;
    logic        s_end_of_input = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic        m_payload_valid;
    logic [7:0]  m_payload_byte;
    logic [2:0]  m_status;
    logic [31:0] m_body_length;
    logic [31:0] m_consumed_bytes;

    // Mirror of the decoder's message state and its one register.
    phase_t      frame_phase = PH_SIZE;
    int unsigned line_len    = 0;
    logic [63:0] size_acc    = 64'd0;
    logic        past_digits = 1'b0;
    logic [63:0] chunk_left  = 64'd0;
    logic [31:0] body_count  = 32'd0;
    logic [31:0] byte_count  = 32'd0;
    logic        last_chunk  = 1'b0;
    logic [31:0] body_limit  = MAX_BODY_RESET;

    byte_item_t  body_stream[$];
    byte_item_t  dir_table[$];
    decoded_t    decoded_due[$];
    logic [7:0]  msg_bytes[$];

    byte_item_t  in_flight;
    decoded_t    step_res;
    logic        step_has;
    decoded_t    due;

    int          error_count   = 0;
    int          cycle_count   = 0;
    int          random_items  = 0;
    int          gap_left      = 0;
    int          burst_left    = 0;
    logic        sender_steady = 1'b0;
    rx_mode_t    rx_mode       = RX_MOSTLY;
    int          rx_tick       = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;

    http_chunked_body_decoder #(
        .SIZE_LINE_LIMIT (LINE_LIMIT),
        .CHUNK_SIZE_BITS (SIZE_BITS)
    ) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_input   (s_end_of_input),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_payload_valid  (m_payload_valid),
        .m_payload_byte   (m_payload_byte),
        .m_status         (m_status),
        .m_body_length    (m_body_length),
        .m_consumed_bytes (m_consumed_bytes)
    );

    always #5 aclk = ~aclk;

    // Value of an ASCII hex digit in either case, -1 for anything else.
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    // Advance the mirrored message state by one byte; return 1 when the byte
    // yields a transaction, which is then left in r.
    function automatic logic decode_byte(input logic [7:0] c, input logic eoi,
                                         output decoded_t r);
        status_t     st;
        logic        pv;
        logic [63:0] lim;
        logic [63:0] tot;
        int          hv;
        st = ST_NONE;
        pv = 1'b0;
        r  = '0;
        if (byte_count != 32'hFFFF_FFFF) byte_count = byte_count + 32'd1;
        case (frame_phase)
            PH_SIZE: begin
                if (c == CH_CR) begin
                    lim = {32'd0, body_limit};
                    tot = {32'd0, body_count};
                    if (tot > lim || size_acc > lim - tot) st = ST_BIG;
                    else frame_phase = PH_SIZE_LF;
                end else if (line_len + 1 >= LINE_LIMIT) begin
                    st = ST_LONG;
                end else begin
                    line_len = line_len + 1;
                    if (!past_digits) begin
                        hv = hex_nibble(c);
                        if (hv < 0) past_digits = 1'b1;
                        else if ((size_acc >> (SIZE_BITS - 4)) != 0) st = ST_OVF;
                        else size_acc = (size_acc << 4) | 64'(hv);
                    end
                end
            end
            PH_SIZE_LF: begin
                if (c != CH_LF) begin
                    st = ST_BADEND;
                end else if (size_acc == 64'd0) begin
                    last_chunk  = 1'b1;
                    frame_phase = PH_DATA_CR;
                end else begin
                    chunk_left  = size_acc;
                    frame_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                pv         = 1'b1;
                body_count = body_count + 32'd1;
                if (chunk_left != 64'd0) chunk_left = chunk_left - 64'd1;
                if (chunk_left == 64'd0) frame_phase = PH_DATA_CR;
            end
            PH_DATA_CR: begin
                if (c != CH_CR) st = ST_BADEND;
                else frame_phase = PH_DATA_LF;
            end
            default: begin
                if (c != CH_LF) begin
                    st = ST_BADEND;
                end else if (last_chunk) begin
                    st               = ST_DONE;
                    r.body_length    = body_count;
                    r.consumed_bytes = byte_count;
                end else begin
                    frame_phase = PH_SIZE;
                    line_len    = 0;
                    size_acc    = 64'd0;
                    past_digits = 1'b0;
                end
            end
        endcase
        if (st == ST_NONE && eoi) st = ST_TRUNC;
        if (st != ST_NONE) begin
            frame_phase = PH_SIZE;
            line_len    = 0;
            size_acc    = 64'd0;
            past_digits = 1'b0;
            chunk_left  = 64'd0;
            body_count  = 32'd0;
            byte_count  = 32'd0;
            last_chunk  = 1'b0;
        end
        r.payload_valid = pv;
        r.payload_byte  = pv ? c : 8'd0;
        r.status        = st;
        return pv || (st != ST_NONE);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 10) return 8'("0") + 8'(d);
        return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(d) - 8'd10;
    endfunction

    // Any bytes but CR: extension text and over-long lines.
    task automatic add_filler(input int n);
        logic [7:0] b;
        repeat (n) begin
            do b = 8'($urandom_range(255)); while (b == CH_CR);
            msg_bytes.push_back(b);
        end
    endtask

    task automatic add_size_line(input logic [63:0] v, input logic allow_ext);
        int nd;
        int i;
        nd = 1;
        while (nd < 16 && (v >> (4 * nd)) != 0) nd++;
        repeat ($urandom_range(2)) msg_bytes.push_back("0");
        for (i = nd - 1; i >= 0; i--) msg_bytes.push_back(hex_char(v[4 * i +: 4]));
        if (allow_ext && $urandom_range(3) == 0) begin
            msg_bytes.push_back(";");
            add_filler($urandom_range(6, 1));
        end
        msg_bytes.push_back(CH_CR);
        msg_bytes.push_back(CH_LF);
    endtask

    task automatic add_payload(input int n);
        repeat (n) msg_bytes.push_back(8'($urandom_range(255)));
    endtask

    // Move the built message onto the stream; optionally cut it short with
    // end_of_input, and now and then raise end_of_input anywhere.
    task automatic commit_message(input logic may_cut);
        int         cut;
        int         i;
        byte_item_t item;
        cut = (may_cut && $urandom_range(7) == 0) ?
              int'($urandom_range(msg_bytes.size() - 1)) : -1;
        for (i = 0; i < msg_bytes.size(); i++) begin
            item              = '0;
            item.data_byte    = msg_bytes[i];
            item.end_of_input = (i == cut) || ($urandom_range(299) == 0);
            body_stream.push_back(item);
            random_items++;
            if (i == cut) break;
        end
        msg_bytes.delete();
    endtask

    task automatic queue_random_message();
        int         kind;
        int         sz;
        int         n;
        int         variant;
        logic [7:0] b;
        msg_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 70) begin
            // Well-formed message: a few small chunks, then the zero chunk.
            repeat ($urandom_range(3)) begin
                sz = ($urandom_range(7) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
                add_size_line(64'(sz), 1'b1);
                add_payload(sz);
                msg_bytes.push_back(CH_CR);
                msg_bytes.push_back(CH_LF);
            end
            if ($urandom_range(4) == 0) begin
                // A size line without digits reads as the zero chunk.
                msg_bytes.push_back(";");
                add_filler($urandom_range(4));
                msg_bytes.push_back(CH_CR);
                msg_bytes.push_back(CH_LF);
            end else begin
                add_size_line(64'd0, 1'b1);
            end
            msg_bytes.push_back(CH_CR);
            msg_bytes.push_back(CH_LF);
            commit_message(1'b1);
        end else if (kind < 78) begin
            // Size line straddling the length limit.
            n = $urandom_range(LINE_LIMIT + 3, LINE_LIMIT - 3);
            msg_bytes.push_back("0");
            msg_bytes.push_back(";");
            add_filler(n - 2);
            msg_bytes.push_back(CH_CR);
            msg_bytes.push_back(CH_LF);
            msg_bytes.push_back(CH_CR);
            msg_bytes.push_back(CH_LF);
            commit_message(1'b0);
        end else if (kind < 85) begin
            // More significant hex digits than the size can hold.
            n = $urandom_range(18, 17);
            msg_bytes.push_back(hex_char(4'($urandom_range(15, 1))));
            repeat (n - 1) msg_bytes.push_back(hex_char(4'($urandom_range(15))));
            msg_bytes.push_back(CH_CR);
            msg_bytes.push_back(CH_LF);
            commit_message(1'b0);
        end else if (kind < 90) begin
            // Size past any 32-bit limit; stop after its CR.
            n = $urandom_range(16, 9);
            msg_bytes.push_back(hex_char(4'($urandom_range(15, 1))));
            repeat (n - 1) msg_bytes.push_back(hex_char(4'($urandom_range(15))));
            msg_bytes.push_back(CH_CR);
            commit_message(1'b0);
        end else if (kind < 94) begin
            // Broken line end after a size line or after a payload.
            sz      = $urandom_range(3, 1);
            variant = $urandom_range(2);
            case (variant)
                0: begin
                    msg_bytes.push_back(hex_char(4'(sz)));
                    msg_bytes.push_back(CH_CR);
                end
                1: begin
                    add_size_line(64'(sz), 1'b0);
                    add_payload(sz);
                end
                default: begin
                    add_size_line(64'(sz), 1'b0);
                    add_payload(sz);
                    msg_bytes.push_back(CH_CR);
                end
            endcase
            do b = 8'($urandom_range(255)); while (b == ((variant == 1) ? CH_CR : CH_LF));
            msg_bytes.push_back(b);
            commit_message(1'b0);
        end else begin
            // Noise, heavy on line-end bytes and digits.
            repeat ($urandom_range(12, 3)) begin
                case ($urandom_range(3))
                    0: msg_bytes.push_back(CH_CR);
                    1: msg_bytes.push_back(CH_LF);
                    2: msg_bytes.push_back(hex_char(4'($urandom_range(15))));
                    default: msg_bytes.push_back(8'($urandom_range(255)));
                endcase
            end
            commit_message(1'b1);
        end
    endtask

    task automatic dir_row(input logic [7:0] b, input logic eoi, input logic fixed,
                           input logic has, input status_t st,
                           input logic [31:0] blen, input logic [31:0] cons);
        byte_item_t item;
        item                          = '0;
        item.data_byte                = b;
        item.end_of_input             = eoi;
        item.fixed                    = fixed;
        item.fixed_has                = has;
        item.fixed_res.status         = st;
        item.fixed_res.body_length    = blen;
        item.fixed_res.consumed_bytes = cons;
        dir_table.push_back(item);
    endtask

    // Hold until the stream is drained and nothing is due, then pad.
    task automatic wait_idle();
        do @(posedge aclk); while (body_stream.size() != 0 || s_valid || decoded_due.size() != 0);
        repeat (LATENCY_PAD) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        body_limit   = v;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Sender: predict each accepted transaction, then offer the next byte in
    // bursts with random gaps (none when steady); hold the payload while the block stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                step_has = decode_byte(in_flight.data_byte, in_flight.end_of_input, step_res);
                if (in_flight.fixed) begin
                    if (in_flight.fixed_has) decoded_due.push_back(in_flight.fixed_res);
                end else if (step_has) begin
                    decoded_due.push_back(step_res);
                end
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (body_stream.size() > 0) begin
                    in_flight       = body_stream.pop_front();
                    s_valid        <= 1'b1;
                    s_data_byte    <= in_flight.data_byte;
                    s_end_of_input <= in_flight.end_of_input;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(24, 1);
                        gap_left   <= sender_steady ? 0 : $urandom_range(6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: a long hold-off on request, otherwise the current pattern.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1;
            if (hold_served != hold_requests) begin
                hold_served <= hold_requests;
                hold_left   <= LONG_HOLD;
                m_ready     <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  m_ready <= 1'b1;
                    RX_MOSTLY:  m_ready <= ($urandom_range(9) < 7);
                    RX_PATTERN: m_ready <= ((rx_tick % 7) < 5);
                    default:    m_ready <= ($urandom_range(9) < 3);
                endcase
            end
        end
    end

    // Compare each accepted transaction with the oldest one due.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (decoded_due.size() == 0) begin
                $display("%0t: expected nothing, got pv=%0d byte=%0h status=%0d len=%0h cons=%0h",
                         $time, m_payload_valid, m_payload_byte, m_status,
                         m_body_length, m_consumed_bytes);
                error_count++;
            end else begin
                due = decoded_due.pop_front();
                check_field("payload_valid", 32'(due.payload_valid), 32'(m_payload_valid));
                check_field("payload_byte", 32'(due.payload_byte), 32'(m_payload_byte));
                check_field("status", 32'(due.status), 32'(m_status));
                check_field("body_length", due.body_length, m_body_length);
                check_field("consumed_bytes", due.consumed_bytes, m_consumed_bytes);
            end
        end
    end

    // Give up on a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("http_chunked_body_decoder_tb: done, errors");
            $finish;
        end
    end

    initial begin : main_seq
        int i;
        int p;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table: byte, end_of_input, typed, has result, status, length, consumed.
        // Empty message: the zero chunk alone.
        dir_row("0",    1'b0, 1'b1, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_CR,  1'b0, 1'b1, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_LF,  1'b0, 1'b1, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_CR,  1'b0, 1'b1, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_LF,  1'b0, 1'b1, 1'b1, ST_DONE, 32'd0, 32'd5);
        // One chunk of the top byte value, then the end.
        dir_row("1",    1'b0, 1'b0, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_CR,  1'b0, 1'b0, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_LF,  1'b0, 1'b0, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(8'hFF,  1'b0, 1'b0, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_CR,  1'b0, 1'b0, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_LF,  1'b0, 1'b0, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row("0",    1'b0, 1'b0, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_CR,  1'b0, 1'b0, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_LF,  1'b0, 1'b0, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_CR,  1'b0, 1'b0, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_LF,  1'b0, 1'b0, 1'b0, ST_NONE, 32'd0, 32'd0);
        // Zero byte where the LF of the size line belongs.
        dir_row("1",    1'b0, 1'b1, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_CR,  1'b0, 1'b1, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(8'h00,  1'b0, 1'b1, 1'b1, ST_BADEND, 32'd0, 32'd0);
        // Input ends inside a size line.
        dir_row("F",    1'b1, 1'b1, 1'b1, ST_TRUNC, 32'd0, 32'd0);
        // One byte more than the reset body limit.
        dir_row("1",    1'b0, 1'b1, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row("0",    1'b0, 1'b1, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row("0",    1'b0, 1'b1, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row("0",    1'b0, 1'b1, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row("0",    1'b0, 1'b1, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row("1",    1'b0, 1'b1, 1'b0, ST_NONE, 32'd0, 32'd0);
        dir_row(CH_CR,  1'b0, 1'b1, 1'b1, ST_BIG, 32'd0, 32'd0);
        for (i = 0; i < dir_table.size(); i++) body_stream.push_back(dir_table[i]);
        wait_idle();

        // Random phases, each under its own body limit and idling pattern.
        for (p = 0; p < PHASES; p++) begin
            case (p)
                1: begin
                    write_limit(32'd0);
                    rx_mode       <= RX_PATTERN;
                    sender_steady <= 1'b0;
                end
                2: begin
                    write_limit(32'hFFFF_FFFF);
                    rx_mode       <= RX_ALWAYS;
                    sender_steady <= 1'b1;
                end
                3: begin
                    write_limit(32'd5);
                    rx_mode       <= RX_SPARSE;
                    sender_steady <= 1'b0;
                end
                4: begin
                    write_limit($urandom());
                    rx_mode       <= RX_ALWAYS;
                    sender_steady <= 1'b1;
                end
                default: begin
                    rx_mode       <= RX_MOSTLY;
                    sender_steady <= 1'b0;
                end
            endcase
            random_items = 0;
            while (random_items < ITEMS_PER_PHASE) queue_random_message();
            if (p == 2) begin
                // Stall the result side while the stream keeps coming, so the
                // block fills and drops s_ready.
                hold_requests <= hold_requests + 1;
                // Leave a message six bytes into its eight-byte payload, so that the
                // lower limit of the next phase meets a body already past it.
                add_size_line(64'd8, 1'b0);
                add_payload(6);
                commit_message(1'b0);
            end
            wait_idle();
        end

        if (error_count == 0 && decoded_due.size() == 0) begin
            $display("http_chunked_body_decoder_tb: done, clean");
        end else begin
            $display("http_chunked_body_decoder_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/hcbd_pkg.sv
src/hcbd_core.sv
src/http_chunked_body_decoder.sv
tb/http_chunked_body_decoder_tb.sv
